// File: src/fnv1a_and_polynomial_hash_unit_macros.svh
// Assertion macros shared by the hash unit RTL.
`ifndef FNV1A_AND_POLYNOMIAL_HASH_UNIT_MACROS_SVH
`define FNV1A_AND_POLYNOMIAL_HASH_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FPH_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fph assertion failed");
// Next-cycle implication.
`define FPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fph assertion failed");
`else
`define FPH_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define FPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// File: src/fph_pkg.sv
// Shared types and constants of the FNV-1a / polynomial hash unit.
package fph_pkg;

   localparam int HASH_W = 64;
   localparam int BYTE_W = 8;
   localparam int WORD_BYTES = HASH_W / BYTE_W;
   localparam int STEP_CNT_W = $clog2(WORD_BYTES + 1);

   localparam logic [HASH_W-1:0] OFFSET_BASIS = 64'hcbf29ce484222325;
   // prime = 2^40 + 0x1b3
   localparam int PRIME_SHIFT = 40;
   localparam logic [8:0] PRIME_LO = 9'h1b3;

   // operation codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_BYTE = 2'd1;
   localparam logic [1:0] OP_WORD = 2'd2;

   // hash modes
   localparam logic MODE_FNV1A = 1'b0;
   localparam logic MODE_POLY  = 1'b1;

   // register map
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic REG_HASH_MODE = 1'b0;

   typedef struct packed {
      logic hash_mode;
   } cfg_type;

endpackage

// File: src/fph_csr.sv
// APB-style configuration register block of the hash unit.
module fph_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fph_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [fph_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [fph_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output fph_pkg::cfg_type               cfg
);
   import fph_pkg::*;

   logic hash_mode_ff;
   logic hash_mode_in;
   logic reg_index;
   logic wr_en;

   // byte offset bits are ignored
   assign reg_index = paddr[CSR_ADDR_W-1];
   assign wr_en     = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      hash_mode_in = hash_mode_ff;
      if (wr_en && reg_index == REG_HASH_MODE) begin
         hash_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_mode_ff <= MODE_FNV1A;
      end else begin
         hash_mode_ff <= hash_mode_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_HASH_MODE: prdata = {{(CSR_DATA_W-1){1'b0}}, hash_mode_ff};
         default:       prdata = '0;
      endcase
   end

   assign cfg.hash_mode = hash_mode_ff;

endmodule

// File: src/fph_mul_unit.sv
// Shared byte-absorb unit: one multiply by the FNV prime mod 2^64.
module fph_mul_unit (
   input  logic                       hash_mode,
   input  logic [fph_pkg::HASH_W-1:0] hash_cur,
   input  logic [fph_pkg::HASH_W-1:0] byte_val,
   output logic [fph_pkg::HASH_W-1:0] hash_next
);
   import fph_pkg::*;

   logic [HASH_W-1:0] mul_src;
   logic [HASH_W-1:0] mul_lo;
   logic [HASH_W-1:0] product;

   // FNV-1a xors before the multiply, polynomial adds after it
   assign mul_src = (hash_mode == MODE_POLY) ? hash_cur : (hash_cur ^ byte_val);
   assign mul_lo  = mul_src * {{(HASH_W-9){1'b0}}, PRIME_LO};
   assign product = (mul_src << PRIME_SHIFT) + mul_lo;
   assign hash_next = (hash_mode == MODE_POLY) ? (product + byte_val) : product;

endmodule

// File: src/fnv1a_and_polynomial_hash_unit.sv
// Top level of the FNV-1a / polynomial running hash unit.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  req     | in        | req_valid / req_stall | req_operation, req_restart, req_data
//  rsp     | out       | rsp_valid / rsp_stall | rsp_hash
//  csr     | in/out    | APB psel/penable      | hash_mode at byte address 0
//
// One item at a time. The accept cycle loads the work registers, then the
// single multiply-by-prime unit absorbs one byte per cycle: a word item takes
// eight byte steps, a byte item one, a no-data item none. Bytes are absorbed
// while the previous hash is unread; the new hash enters the result register once
// the old one is taken, and req_stall is high from acceptance until then.
// Synchronous active-high reset sets the hash to the offset basis and mode FNV-1a.
module fnv1a_and_polynomial_hash_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic                           req_restart,
   input  logic [fph_pkg::HASH_W-1:0]     req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [fph_pkg::HASH_W-1:0]     rsp_hash,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [fph_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [fph_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [fph_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import fph_pkg::*;
   `include "fnv1a_and_polynomial_hash_unit_macros.svh"

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   cfg_type cfg;

   logic                  state_ff,     state_in;
   logic [HASH_W-1:0]     hash_ff,      hash_in;
   logic [HASH_W-1:0]     data_ff,      data_in;
   logic                  sext_ff,      sext_in;
   logic [STEP_CNT_W-1:0] steps_ff,     steps_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]     rsp_hash_ff,  rsp_hash_in;

   logic              accept;
   logic              out_free;
   logic              last_step;
   logic [BYTE_W-1:0] cur_byte;
   logic [HASH_W-1:0] byte_val;
   logic [HASH_W-1:0] step_hash;
   logic [HASH_W-1:0] stage_hash;

   fph_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // byte order: FNV-1a takes the word low byte first, polynomial high byte first
   assign cur_byte = (cfg.hash_mode == MODE_POLY) ? data_ff[HASH_W-1 -: BYTE_W]
                                                  : data_ff[BYTE_W-1:0];
   // string bytes are sign-extended, word bytes are not
   assign byte_val = sext_ff ? {{(HASH_W-BYTE_W){cur_byte[BYTE_W-1]}}, cur_byte}
                             : {{(HASH_W-BYTE_W){1'b0}}, cur_byte};

   fph_mul_unit u_mul (
      .hash_mode (cfg.hash_mode),
      .hash_cur  (hash_ff),
      .byte_val  (byte_val),
      .hash_next (step_hash)
   );

   assign accept     = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_step  = steps_ff <= STEP_CNT_W'(1);
   assign stage_hash = (steps_ff != '0) ? step_hash : hash_ff;

   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      data_in      = data_ff;
      sext_in      = sext_ff;
      steps_in     = steps_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_hash_in  = rsp_hash_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               hash_in  = req_restart ? OFFSET_BASIS : hash_ff;
               data_in  = req_data;
               state_in = ST_BUSY;
               case (req_operation)
                  OP_BYTE: begin
                     // move the string byte to where the selected mode reads it
                     data_in  = {req_data[BYTE_W-1:0], {(HASH_W-2*BYTE_W){1'b0}},
                                 req_data[BYTE_W-1:0]};
                     sext_in  = 1'b1;
                     steps_in = STEP_CNT_W'(1);
                  end
                  OP_WORD: begin
                     sext_in  = 1'b0;
                     steps_in = STEP_CNT_W'(WORD_BYTES);
                  end
                  default: begin
                     // no data, and the unused code behaves the same
                     sext_in  = 1'b0;
                     steps_in = '0;
                  end
               endcase
            end
         end
         ST_BUSY: begin
            if (steps_ff != '0) begin
               hash_in  = step_hash;
               steps_in = steps_ff - STEP_CNT_W'(1);
               data_in  = (cfg.hash_mode == MODE_POLY) ? (data_ff << BYTE_W)
                                                       : (data_ff >> BYTE_W);
            end
            if (last_step && out_free) begin
               rsp_hash_in  = stage_hash;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hash_ff      <= OFFSET_BASIS;
         sext_ff      <= 1'b0;
         steps_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         hash_ff      <= hash_in;
         sext_ff      <= sext_in;
         steps_ff     <= steps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

   `FPH_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, req_stall)
   `FPH_ASSERT_IMPLIES(a_steps_range, clock, reset, 1'b1, steps_ff <= STEP_CNT_W'(WORD_BYTES))
   `FPH_ASSERT_IMPLIES(a_idle_no_steps, clock, reset, state_ff == ST_IDLE, steps_ff == '0)
   `FPH_ASSERT_NEXT(a_rsp_only_from_busy, clock, reset, state_ff == ST_IDLE && !rsp_valid_ff, !rsp_valid_ff)

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the FNV-1a / polynomial running hash unit.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fph_pkg::*;

   // Spare operation code: behaves like a no-data item.
   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};

   // ---------------------------------------------------------------------
   // Expected-hash tracker: mirrors the running hash and the mode, and
   // queues one expected hash per accepted item.
   // ---------------------------------------------------------------------
   class hash_tracker;
      localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;

      logic [HASH_W-1:0] running_hash;
      logic              mode;
      logic [HASH_W-1:0] pending_hashes[$];
      int                error_count;

      function new();
         running_hash = OFFSET_BASIS;
         mode         = MODE_FNV1A;
         error_count  = 0;
      endfunction

      function void set_mode(logic m);
         mode = m;
      endfunction

      function int pending();
         return pending_hashes.size();
      endfunction

      // One byte step in the current mode.
      function void fold_byte(logic [HASH_W-1:0] v);
         if (mode == MODE_POLY) begin
            running_hash = running_hash * FNV_PRIME + v;
         end else begin
            running_hash = (running_hash ^ v) * FNV_PRIME;
         end
      endfunction

      // Accepted request: update the running hash and queue the result.
      function void note_item(logic [1:0] op, logic restart, logic [HASH_W-1:0] data);
         if (restart) begin
            running_hash = OFFSET_BASIS;
         end
         case (op)
            OP_BYTE: begin
               // string bytes behave as signed chars
               fold_byte({{(HASH_W-BYTE_W){data[BYTE_W-1]}}, data[BYTE_W-1:0]});
            end
            OP_WORD: begin
               for (int k = 0; k < WORD_BYTES; k++) begin
                  if (mode == MODE_POLY) begin
                     fold_byte(HASH_W'(data[HASH_W-1-BYTE_W*k -: BYTE_W]));
                  end else begin
                     fold_byte(HASH_W'(data[BYTE_W*k +: BYTE_W]));
                  end
               end
            end
            default: ;
         endcase
         pending_hashes.push_back(running_hash);
      endfunction

      function void check_hash(logic [HASH_W-1:0] actual);
         logic [HASH_W-1:0] want;
         if (pending_hashes.size() == 0) begin
            $error("hash: no item outstanding, actual %h", actual);
            error_count++;
         end else begin
            want = pending_hashes.pop_front();
            if (actual !== want) begin
               $error("hash mismatch: expected %h, actual %h", want, actual);
               error_count++;
            end
         end
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // DUT signals and instance
   // ---------------------------------------------------------------------
   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_operation;
   logic                  req_restart;
   logic [HASH_W-1:0]     req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [HASH_W-1:0]     rsp_hash;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fnv1a_and_polynomial_hash_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_restart   (req_restart),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_hash      (rsp_hash),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   hash_tracker tracker;
   bit          idling_on;   // random gaps and stalls allowed
   int          stall_left;

   // 100 MHz clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop: the slowest legal run is well under half a millisecond.
   initial begin
      #5ms;
      $display("FAIL fnv1a_and_polynomial_hash_unit");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: check every accepted hash, stall in short random bursts.
   // Sampling right after the edge sees pre-edge values of all signals.
   // ---------------------------------------------------------------------
   initial begin
      rsp_stall  <= 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            tracker.check_hash(rsp_hash);
         end
         if (idling_on && stall_left == 0 && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (idling_on && stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = 0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver tasks. All are entered right after a rising edge.
   // ---------------------------------------------------------------------

   // Present one item, hold it until accepted, then maybe leave a gap.
   // valid is not lowered here unless a gap follows, so back-to-back
   // items keep it high without a second assignment in one step.
   task automatic send_item(logic [1:0] op, logic restart, logic [HASH_W-1:0] data);
      int gap;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_restart   <= restart;
      req_data      <= data;
      do @(posedge clock); while (req_stall);
      tracker.note_item(op, restart, data);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and wait until every queued hash has come back.
   task automatic drain_hashes();
      req_valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write of hash_mode: setup cycle, then access until pready.
   task automatic write_hash_mode(logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(4 * REG_HASH_MODE);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.set_mode(value[0]);
   endtask

   // Random item: mostly byte and word data, restarts now and then,
   // a few no-data and spare-code items; data sometimes at the extremes.
   task automatic send_random_item();
      int                r;
      logic [1:0]        op;
      logic              restart;
      logic [HASH_W-1:0] data;
      r = $urandom_range(0, 99);
      if (r < 42)      op = OP_BYTE;
      else if (r < 84) op = OP_WORD;
      else if (r < 94) op = OP_NONE;
      else             op = OP_SPARE;
      restart = ($urandom_range(0, 15) == 0);
      data    = {$urandom, $urandom};
      case ($urandom_range(0, 31))
         0: data = '0;
         1: data = ALL_ONES;
         default: ;
      endcase
      send_item(op, restart, data);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      logic mode_seq[6];
      tracker   = new();
      idling_on = 1'b1;

      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_NONE;
      req_restart   <= 1'b0;
      req_data      <= '0;
      csr_psel      <= 1'b0;
      csr_penable   <= 1'b0;
      csr_pwrite    <= 1'b0;
      csr_paddr     <= '0;
      csr_pwdata    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed FNV-1a: first byte hashes from the reset basis, then
      // the sign edge of string bytes, ignored upper bits, word extremes,
      // restart-only and spare-code items with and without restart.
      write_hash_mode(CSR_DATA_W'(MODE_FNV1A));
      send_item(OP_BYTE,  1'b0, 64'h0);
      send_item(OP_BYTE,  1'b0, 64'h7f);
      send_item(OP_BYTE,  1'b0, 64'h80);
      send_item(OP_BYTE,  1'b0, 64'hdeadbeef_cafe0081);
      send_item(OP_BYTE,  1'b0, ALL_ONES);
      send_item(OP_WORD,  1'b0, 64'h0);
      send_item(OP_WORD,  1'b1, ALL_ONES);
      send_item(OP_WORD,  1'b0, 64'h01234567_89abcdef);
      send_item(OP_NONE,  1'b1, 64'h5a5a5a5a_a5a5a5a5);
      send_item(OP_NONE,  1'b0, ALL_ONES);
      send_item(OP_SPARE, 1'b0, 64'h0);
      send_item(OP_SPARE, 1'b1, ALL_ONES);
      send_item(OP_BYTE,  1'b1, 64'h61);
      drain_hashes();

      // Directed polynomial mode; the hash carries over from FNV-1a.
      write_hash_mode(CSR_DATA_W'(MODE_POLY));
      send_item(OP_BYTE,  1'b0, 64'h80);
      send_item(OP_BYTE,  1'b1, 64'hff);
      send_item(OP_BYTE,  1'b0, 64'hffffff00_0000007f);
      send_item(OP_WORD,  1'b0, 64'h01234567_89abcdef);
      send_item(OP_WORD,  1'b1, ALL_ONES);
      send_item(OP_WORD,  1'b0, 64'h0);
      send_item(OP_NONE,  1'b1, 64'h0);
      send_item(OP_SPARE, 1'b0, ALL_ONES);
      send_item(OP_SPARE, 1'b1, 64'h0);
      drain_hashes();

      // Random phases, with the modes taken from mode_seq. Only bit 0 of the write data
      // holds the mode, so the upper bits get random junk.
      mode_seq = '{MODE_FNV1A, MODE_POLY, MODE_FNV1A, MODE_POLY, MODE_POLY, MODE_FNV1A};
      for (int p = 0; p < 6; p++) begin
         write_hash_mode({$urandom_range(0, 1) ? $urandom : 32'h0} & ~32'h1
                         | CSR_DATA_W'(mode_seq[p]));
         if (p == 5) begin
            idling_on = 1'b0;   // full-rate finish
         end
         for (int i = 0; i < 320; i++) begin
            // hold off mid-phase until the unit has emptied
            if (p == 2 && i == 160) begin
               drain_hashes();
            end
            send_random_item();
         end
         drain_hashes();
      end

      // Let any stray result show up before the verdict.
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) begin
         $error("hash: %0d expected results never arrived", tracker.pending());
         tracker.error_count++;
      end
      if (tracker.error_count == 0) begin
         $display("PASS fnv1a_and_polynomial_hash_unit");
      end else begin
         $display("FAIL fnv1a_and_polynomial_hash_unit");
      end
      $finish;
   end

endmodule
